FILE: hdl/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types, codes and the control program of the max-xor trie block.
// ----------------------------------------------------------------------------
package btmx_pkg;

  // item kinds
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] partner;
    logic [1:0]  status;
  } out_beat_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_INS_START,
    OP_INS_STEP,
    OP_QRY_START,
    OP_QRY_STEP,
    OP_EMIT
  } op_t;

  // sequencing of one step
  typedef enum logic [2:0] {
    SEQ_FETCH,   // wait for an input beat, then dispatch on mode
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_JSTOP,   // jump to target when the datapath flags stop
    SEQ_LOOP,    // repeat target until the last level, then emit
    SEQ_EMIT     // wait for the output register, then fetch
  } seq_t;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_FETCH    = 3'd0;
  localparam upc_t UA_CLEAR    = 3'd1;
  localparam upc_t UA_INS      = 3'd2;
  localparam upc_t UA_INS_STEP = 3'd3;
  localparam upc_t UA_EMIT     = 3'd4;
  localparam upc_t UA_QRY      = 3'd5;
  localparam upc_t UA_QRY_STEP = 3'd6;

  typedef struct packed {
    op_t  op;
    seq_t seq;
    upc_t target;
  } ucode_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic stop;
    logic last;
    logic out_busy;
  } cond_t;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    unique case (addr)
      UA_FETCH:    w = '{op: OP_LOAD,      seq: SEQ_FETCH, target: UA_FETCH};
      UA_CLEAR:    w = '{op: OP_CLEAR,     seq: SEQ_JUMP,  target: UA_EMIT};
      UA_INS:      w = '{op: OP_INS_START, seq: SEQ_JSTOP, target: UA_EMIT};
      UA_INS_STEP: w = '{op: OP_INS_STEP,  seq: SEQ_LOOP,  target: UA_INS_STEP};
      UA_EMIT:     w = '{op: OP_EMIT,      seq: SEQ_EMIT,  target: UA_FETCH};
      UA_QRY:      w = '{op: OP_QRY_START, seq: SEQ_JSTOP, target: UA_EMIT};
      UA_QRY_STEP: w = '{op: OP_QRY_STEP,  seq: SEQ_LOOP,  target: UA_QRY_STEP};
      default:     w = '{op: OP_NONE,      seq: SEQ_JUMP,  target: UA_FETCH};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(input logic [1:0] mode);
    upc_t a;
    unique case (mode)
      MODE_CLEAR:  a = UA_CLEAR;
      MODE_INSERT: a = UA_INS;
      MODE_QUERY:  a = UA_QRY;
      default:     a = UA_EMIT;   // unused mode: zero result
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/btmx_ram.sv
// ----------------------------------------------------------------------------
// btmx_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btmx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/btmx_useq.sv
// ----------------------------------------------------------------------------
// btmx_useq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module btmx_useq
  import btmx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  input  cond_t      cond,
  output ucode_t     uc,
  output logic       in_ready
);

  upc_t upc_r, upc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // next step
  always_comb begin
    upc_nxt = upc_r;
    unique case (uc.seq)
      SEQ_FETCH: if (in_valid) upc_nxt = dispatch(in_mode);
      SEQ_NEXT:  upc_nxt = upc_r + upc_t'(1);
      SEQ_JUMP:  upc_nxt = uc.target;
      SEQ_JSTOP: upc_nxt = cond.stop ? uc.target : upc_r + upc_t'(1);
      SEQ_LOOP:  upc_nxt = cond.last ? UA_EMIT : uc.target;
      SEQ_EMIT:  if (!cond.out_busy) upc_nxt = uc.target;
      default:   upc_nxt = UA_FETCH;
    endcase
  end

  // control word out
  always_comb begin
    uc       = ucode_rom(upc_r);
    in_ready = (uc.seq == SEQ_FETCH);
  end

endmodule

FILE: hdl/btmx_dp.sv
// ----------------------------------------------------------------------------
// btmx_dp
// Trie datapath: node pool, walk registers, allocation count, result register.
// ----------------------------------------------------------------------------
module btmx_dp
  import btmx_pkg::*;
#(
  parameter int NODE_POOL  = 32768,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ucode_t    uc,
  input  logic      in_valid,
  input  in_beat_t  in_data,
  output cond_t     cond,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int IDX_W = $clog2(NODE_POOL);
  localparam int CNT_W = $clog2(NODE_POOL + 1);
  localparam int LVL_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int LNK_W = IDX_W + 1;          // valid + index
  localparam int ENT_W = 2 * LNK_W;          // {hi link, lo link}
  localparam int CMP_W = CNT_W + 8;

  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] ans_r, ans_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic                  fresh_r, fresh_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt;
  logic [CNT_W-1:0]      nodes_r, nodes_nxt;
  logic                  root_r, root_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [ENT_W-1:0]      wr_data, rd_data;

  logic [ENT_W-1:0]      entry;
  logic [LNK_W-1:0]      lo_link, hi_link, slot;
  logic [LNK_W-1:0]      new_link;
  logic                  bit_q, take_lo, refuse, out_busy;

  btmx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_POOL)
  ) u_pool (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // a node allocated during this insert has no links yet; skip its read
  assign entry    = fresh_r ? '0 : rd_data;
  assign lo_link  = entry[LNK_W-1:0];
  assign hi_link  = entry[ENT_W-1:LNK_W];
  assign bit_q    = key_r[level_r];
  assign slot     = bit_q ? hi_link : lo_link;
  assign new_link = {1'b1, nodes_r[IDX_W-1:0]};
  assign take_lo  = (bit_q && lo_link[LNK_W-1]) || !hi_link[LNK_W-1];
  assign refuse   = (CMP_W'(nodes_r) + CMP_W'(VALUE_BITS + 1)) > CMP_W'(NODE_POOL);
  assign out_busy = out_valid_r && !out_ready;

  assign cond.stop     = ((uc.op == OP_INS_START) && refuse) ||
                         ((uc.op == OP_QRY_START) && !root_r);
  assign cond.last     = (level_r == '0);
  assign cond.out_busy = out_busy;

  always_comb begin
    key_nxt       = key_r;
    ans_nxt       = ans_r;
    status_nxt    = status_r;
    cur_nxt       = cur_r;
    fresh_nxt     = fresh_r;
    level_nxt     = level_r;
    nodes_nxt     = nodes_r;
    root_nxt      = root_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = entry;
    rd_en         = 1'b0;
    rd_addr       = cur_r;

    unique case (uc.op)
      OP_LOAD: begin
        if (in_valid) begin
          key_nxt    = VALUE_BITS'(in_data.value);
          ans_nxt    = '0;
          status_nxt = ST_OK;
        end
      end
      OP_CLEAR: begin
        root_nxt  = 1'b0;
        nodes_nxt = '0;
      end
      OP_INS_START: begin
        if (refuse) begin
          status_nxt = ST_FULL;
        end else begin
          cur_nxt   = '0;
          level_nxt = LVL_W'(VALUE_BITS - 1);
          if (!root_r) begin
            root_nxt  = 1'b1;
            nodes_nxt = CNT_W'(1);
            fresh_nxt = 1'b1;
          end else begin
            fresh_nxt = 1'b0;
            rd_en     = 1'b1;
            rd_addr   = '0;
          end
        end
      end
      OP_INS_STEP: begin
        level_nxt = level_r - LVL_W'(1);
        if (slot[LNK_W-1]) begin
          cur_nxt   = slot[IDX_W-1:0];
          fresh_nxt = 1'b0;
          rd_en     = 1'b1;
          rd_addr   = slot[IDX_W-1:0];
        end else begin
          // link a new node into the missing slot
          wr_en     = 1'b1;
          wr_data   = bit_q ? {new_link, lo_link} : {hi_link, new_link};
          cur_nxt   = nodes_r[IDX_W-1:0];
          fresh_nxt = 1'b1;
          nodes_nxt = nodes_r + CNT_W'(1);
        end
      end
      OP_QRY_START: begin
        if (!root_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          cur_nxt   = '0;
          fresh_nxt = 1'b0;
          level_nxt = LVL_W'(VALUE_BITS - 1);
          rd_en     = 1'b1;
          rd_addr   = '0;
        end
      end
      OP_QRY_STEP: begin
        level_nxt        = level_r - LVL_W'(1);
        ans_nxt[level_r] = !take_lo;
        cur_nxt          = take_lo ? lo_link[IDX_W-1:0] : hi_link[IDX_W-1:0];
        rd_en            = 1'b1;
        rd_addr          = cur_nxt;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_nxt.partner = 32'(ans_r);
          out_nxt.status  = status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r     <= '0;
      root_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fresh_r     <= 1'b0;
      level_r     <= '0;
    end else begin
      nodes_r     <= nodes_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
      fresh_r     <= fresh_nxt;
      level_r     <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    ans_r    <= ans_nxt;
    status_r <= status_nxt;
    cur_r    <= cur_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pool never overruns: inserts are refused before they could
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r <= CNT_W'(NODE_POOL))
    else $error("node count beyond pool");

  // no root means no nodes in use
  a_root_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    !root_r |-> (nodes_r == '0))
    else $error("nodes in use without a root");

  // the pool is only written while an insert walks the trie
  a_wr_insert: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((uc.op == OP_INS_STEP) && root_r))
    else $error("pool write outside insert");

  // a query walk only runs on a non-empty trie
  a_qry_root: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.op == OP_QRY_STEP) |-> root_r)
    else $error("query walk on empty trie");

endmodule

FILE: hdl/binary_trie_max_xor_top.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_top
// Max-xor binary trie: clear, insert and query beats, one result beat each.
// ----------------------------------------------------------------------------
// Insert and query walk the trie from the top value bit down, one level per step,
// with node reads through the node pool's registered read port.
// A new beat is taken only once the previous beat's result is registered.
// Reset empties the trie at once (no pool sweep); pool contents are not reset.
module binary_trie_max_xor_top
  import btmx_pkg::*;
#(
  parameter int NODE_POOL  = 32768,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  ucode_t uc;
  cond_t  cond;

  btmx_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .cond     (cond),
    .uc       (uc),
    .in_ready (in_ready)
  );

  btmx_dp #(
    .NODE_POOL  (NODE_POOL),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uc        (uc),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cond      (cond),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
